// ===== rtl/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// cdt_pkg: shared types, constants and helpers for the countdown timer
// Holds the word formats, request and register codes, the digit font and
// the small arithmetic helpers used by the load pipeline and the state stage.
// ----------------------------------------------------------------------------
package cdt_pkg;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_PAUSE = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;
    localparam logic [1:0] REQ_PIXEL = 2'd3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUNNING    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_END        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLON      = 3'd4;

    // Register reset values
    localparam logic [31:0] RST_BACKGROUND = 32'h0000_0000;
    localparam logic [31:0] RST_RUNNING    = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_END        = 32'hFFFF_0000;
    localparam logic [31:0] RST_DIM        = 32'hFF40_4040;
    localparam logic [31:0] RST_COLON      = 32'hFF80_8080;

    // Time arithmetic
    localparam logic [18:0] LOAD_LIMIT    = 19'd359999;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [6:0]  SECS_PER_MIN  = 7'd60;
    // floor(s / 3600) = (s * HOUR_RECIP) >> HOUR_SHIFT for s <= 359999
    localparam logic [18:0] HOUR_RECIP    = 19'd298262;
    localparam int          HOUR_SHIFT    = 30;
    // floor(r / 60) = (r * MIN_RECIP) >> MIN_SHIFT for r < 3600
    localparam logic [12:0] MIN_RECIP     = 13'd4370;
    localparam int          MIN_SHIFT     = 18;

    // Face geometry
    localparam logic [4:0] FACE_W    = 5'd29;
    localparam logic [4:0] COLON_X0  = 5'd9;
    localparam logic [4:0] COLON_X1  = 5'd19;
    localparam logic [2:0] COLON_Y0  = 3'd1;
    localparam logic [2:0] COLON_Y1  = 3'd3;

    // 3x3 font, one row a word, bit 2 is the leftmost column
    localparam logic [2:0] GLYPH [10][3] = '{
        '{3'd7, 3'd5, 3'd7}, '{3'd6, 3'd2, 3'd7}, '{3'd6, 3'd2, 3'd3},
        '{3'd6, 3'd3, 3'd6}, '{3'd5, 3'd7, 3'd1}, '{3'd3, 3'd2, 3'd6},
        '{3'd4, 3'd7, 3'd7}, '{3'd7, 3'd1, 3'd1}, '{3'd7, 3'd7, 3'd7},
        '{3'd7, 3'd7, 3'd1}
    };

    typedef struct packed {
        logic [1:0]  req_type;
        logic [18:0] load_seconds;
        logic [4:0]  pixel_x;
        logic [2:0]  pixel_y;
    } t_in_word;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic [6:0]  hours_left;
        logic [5:0]  minutes_left;
        logic [5:0]  seconds_left;
        logic        is_paused;
        logic        is_finished;
        logic        load_rejected;
    } t_out_word;

    typedef struct packed {
        logic [31:0] background_color;
        logic [31:0] running_color;
        logic [31:0] end_color;
        logic [31:0] dim_color;
        logic [31:0] colon_color;
    } t_colors;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } t_bcd;

    typedef struct packed {
        t_bcd hrs;
        t_bcd mins;
        t_bcd secs;
        logic paused;
        logic finished;
    } t_timer_state;

    // Request fields that ride along the load pipeline
    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] pixel_x;
        logic [2:0] pixel_y;
        logic       too_big;
        logic       is_zero;
    } t_item_ctl;

    // Word handed from the load pipeline to the state stage
    typedef struct packed {
        t_item_ctl  ctl;
        t_bcd       hrs;
        t_bcd       mins;
        logic [5:0] secs;
    } t_prep_word;

    // Split a value below 100 into decimal digits
    function automatic t_bcd split_bcd(input logic [6:0] v);
        t_bcd r;
        r.tens = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (v >= 7'(i * 10)) begin
                r.tens = 4'(i);
            end
        end
        r.ones = 4'(v - 7'(r.tens) * 7'd10);
        return r;
    endfunction

    // Join two decimal digits into a binary value
    function automatic logic [6:0] bcd_to_bin(input t_bcd b);
        return 7'(b.tens) * 7'd10 + 7'(b.ones);
    endfunction

    // One font row of a digit, codes above nine draw a nine
    function automatic logic [2:0] glyph_row(input logic [3:0] d, input logic [1:0] r);
        logic [3:0] dd;
        dd = (d > 4'd9) ? 4'd9 : d;
        return GLYPH[dd][r];
    endfunction

endpackage

// ===== rtl/cdt_prep.sv =====
// ----------------------------------------------------------------------------
// cdt_prep: load conversion pipeline
// Five register stages turn the loaded second count into hour and minute
// digits and a binary second count, with constant reciprocals in place of
// division. Stages only hold when the stage after them is full and held.
// ----------------------------------------------------------------------------
module cdt_prep
    import cdt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_word   i_in_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_prep_word o_word
);

    // Stage valids
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // Stage payloads
    t_item_ctl   r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [18:0] r_sec1, r_sec2;
    logic [6:0]  r_hrs2, r_hrs3_bin;
    logic [11:0] r_rem3, r_rem4;
    t_bcd        r_hbcd3, r_hbcd4;
    logic [5:0]  r_min4;
    t_prep_word  r_word5;

    logic [37:0] hour_prod;
    logic [18:0] rem_full;
    logic [24:0] min_prod;
    logic [11:0] sec_full;
    t_item_ctl   n_ctl1;

    // Ready chain: a stage takes a word when empty or when it moves on
    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign o_valid = r_v5;
    assign o_word  = r_word5;

    // Capture request fields and flag out-of-range and zero loads
    always_comb begin
        n_ctl1.req_type = i_in_data.req_type;
        n_ctl1.pixel_x  = i_in_data.pixel_x;
        n_ctl1.pixel_y  = i_in_data.pixel_y;
        n_ctl1.too_big  = i_in_data.load_seconds > LOAD_LIMIT;
        n_ctl1.is_zero  = i_in_data.load_seconds == 19'd0;
    end

    // Hours by reciprocal, remainder, minutes by reciprocal, seconds
    always_comb begin
        hour_prod = 38'(r_sec1) * 38'(HOUR_RECIP);
        rem_full  = r_sec2 - 19'(r_hrs2) * 19'(SECS_PER_HOUR);
        min_prod  = 25'(r_rem3) * 25'(MIN_RECIP);
        sec_full  = r_rem4 - 12'(r_min4) * 12'(SECS_PER_MIN);
    end

    // Advance valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // Advance payloads
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_ctl1 <= n_ctl1;
            r_sec1 <= i_in_data.load_seconds;
        end
        if (rdy2) begin
            r_ctl2 <= r_ctl1;
            r_sec2 <= r_sec1;
            r_hrs2 <= hour_prod[HOUR_SHIFT+6:HOUR_SHIFT];
        end
        if (rdy3) begin
            r_ctl3     <= r_ctl2;
            r_rem3     <= rem_full[11:0];
            r_hrs3_bin <= r_hrs2;
            r_hbcd3    <= split_bcd(r_hrs2);
        end
        if (rdy4) begin
            r_ctl4  <= r_ctl3;
            r_rem4  <= r_rem3;
            r_min4  <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
            r_hbcd4 <= r_hbcd3;
        end
        if (rdy5) begin
            r_word5.ctl  <= r_ctl4;
            r_word5.hrs  <= r_hbcd4;
            r_word5.mins <= split_bcd({1'b0, r_min4});
            r_word5.secs <= sec_full[5:0];
        end
    end

`ifndef ASSERT_OFF
    // Reciprocal hours stay in range for accepted loads
    a_hours_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_ctl3.too_big) |-> (r_hrs3_bin <= 7'd99 && r_rem3 < SECS_PER_HOUR))
        else $error("hour conversion out of range");

    // Reciprocal minutes stay in range
    a_mins_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r_ctl4.too_big) |-> (r_min4 < 6'd60 && r_rem4 < SECS_PER_HOUR))
        else $error("minute conversion out of range");

    // Seconds left after minutes stay below one minute
    a_secs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !r_word5.ctl.too_big) |-> (r_word5.secs < 6'd60))
        else $error("second conversion out of range");
`endif

endmodule

// ===== rtl/cdt_pixel.sv =====
// ----------------------------------------------------------------------------
// cdt_pixel: face renderer
// Maps one pixel position to its colour from the current timer state:
// colon pixels, six digit cells with dimmed leading hours and minutes,
// and background elsewhere.
// ----------------------------------------------------------------------------
module cdt_pixel
    import cdt_pkg::*;
(
    input  t_timer_state i_state,
    input  t_colors      i_colors,
    input  logic [4:0]   i_x,
    input  logic [2:0]   i_y,
    output logic [31:0]  o_color
);

    logic        slot_hit;
    logic [2:0]  slot;
    logic [1:0]  dx;
    logic [3:0]  digit;
    logic [31:0] fg;
    logic [31:0] ink;
    logic [2:0]  row_bits;
    logic        hrs_nz;
    logic        mins_nz;
    logic        on_colon;
    logic        in_rows;

    // Locate the digit cell under the column
    always_comb begin
        slot_hit = 1'b1;
        slot     = 3'd0;
        dx       = 2'd0;
        unique case (i_x)
            5'd1, 5'd2, 5'd3: begin
                slot = 3'd0;
                dx   = 2'(i_x - 5'd1);
            end
            5'd5, 5'd6, 5'd7: begin
                slot = 3'd1;
                dx   = 2'(i_x - 5'd5);
            end
            5'd11, 5'd12, 5'd13: begin
                slot = 3'd2;
                dx   = 2'(i_x - 5'd11);
            end
            5'd15, 5'd16, 5'd17: begin
                slot = 3'd3;
                dx   = 2'(i_x - 5'd15);
            end
            5'd21, 5'd22, 5'd23: begin
                slot = 3'd4;
                dx   = 2'(i_x - 5'd21);
            end
            5'd25, 5'd26, 5'd27: begin
                slot = 3'd5;
                dx   = 2'(i_x - 5'd25);
            end
            default: begin
                slot_hit = 1'b0;
            end
        endcase
    end

    // Pick the digit and its ink, dimming leading zero fields
    always_comb begin
        hrs_nz  = (i_state.hrs.tens != 4'd0) || (i_state.hrs.ones != 4'd0);
        mins_nz = (i_state.mins.tens != 4'd0) || (i_state.mins.ones != 4'd0);
        fg      = (i_state.paused || i_state.finished) ? i_colors.end_color
                                                       : i_colors.running_color;
        ink     = fg;
        unique case (slot)
            3'd0:    digit = i_state.hrs.tens;
            3'd1:    digit = i_state.hrs.ones;
            3'd2:    digit = i_state.mins.tens;
            3'd3:    digit = i_state.mins.ones;
            3'd4:    digit = i_state.secs.tens;
            default: digit = i_state.secs.ones;
        endcase
        if (slot < 3'd2 && !(hrs_nz || i_state.finished)) begin
            ink   = i_colors.dim_color;
            digit = 4'd0;
        end else if ((slot == 3'd2 || slot == 3'd3) &&
                     !(mins_nz || hrs_nz || i_state.finished)) begin
            ink   = i_colors.dim_color;
            digit = 4'd0;
        end
    end

    // Resolve the final colour
    always_comb begin
        in_rows  = (i_y >= 3'd1) && (i_y <= 3'd3) && (i_x < FACE_W);
        on_colon = (i_x == COLON_X0 || i_x == COLON_X1) &&
                   (i_y == COLON_Y0 || i_y == COLON_Y1);
        row_bits = glyph_row(digit, 2'(i_y - 3'd1));
        if (!in_rows) begin
            o_color = i_colors.background_color;
        end else if (on_colon) begin
            o_color = i_colors.colon_color;
        end else if (slot_hit && row_bits[2'd2 - dx]) begin
            o_color = ink;
        end else begin
            o_color = i_colors.background_color;
        end
    end

endmodule

// ===== rtl/cdt_core.sv =====
// ----------------------------------------------------------------------------
// cdt_core: timer state stage and result register
// Applies one word a cycle, unless stalled, to the timer state (tick,
// pause, load, pixel read) and registers the result word with the new state.
// ----------------------------------------------------------------------------
module cdt_core
    import cdt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_prep_word i_word,
    input  t_colors    i_colors,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_word  o_out_data
);

    t_timer_state r_state, n_state;
    logic         r_out_valid;
    t_out_word    r_out, n_out;
    logic         advance;
    logic         take;
    logic         last_second;
    logic         rejected;
    logic [31:0]  pix_color;
    logic [31:0]  color;

    localparam t_timer_state DONE_STATE = '{
        hrs: '0, mins: '0, secs: '0, paused: 1'b0, finished: 1'b1};

    // Step the time down by one second, digit by digit
    function automatic t_timer_state dec_time(input t_timer_state s);
        t_timer_state r;
        r = s;
        if (s.secs.ones != 4'd0) begin
            r.secs.ones = s.secs.ones - 4'd1;
        end else begin
            r.secs.ones = 4'd9;
            if (s.secs.tens != 4'd0) begin
                r.secs.tens = s.secs.tens - 4'd1;
            end else begin
                r.secs.tens = 4'd5;
                if (s.mins.ones != 4'd0) begin
                    r.mins.ones = s.mins.ones - 4'd1;
                end else begin
                    r.mins.ones = 4'd9;
                    if (s.mins.tens != 4'd0) begin
                        r.mins.tens = s.mins.tens - 4'd1;
                    end else begin
                        r.mins.tens = 4'd5;
                        if (s.hrs.ones != 4'd0) begin
                            r.hrs.ones = s.hrs.ones - 4'd1;
                        end else begin
                            r.hrs.ones = 4'd9;
                            r.hrs.tens = s.hrs.tens - 4'd1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    assign advance    = !r_out_valid || !i_stall;
    assign take       = i_valid && advance;
    assign o_ready    = advance;
    assign o_valid    = r_out_valid;
    assign o_out_data = r_out;

    cdt_pixel u_pixel (
        .i_state  (r_state),
        .i_colors (i_colors),
        .i_x      (i_word.ctl.pixel_x),
        .i_y      (i_word.ctl.pixel_y),
        .o_color  (pix_color)
    );

    // Apply the request to the timer state
    always_comb begin
        n_state     = r_state;
        rejected    = 1'b0;
        color       = 32'd0;
        last_second = (r_state.hrs == '0) && (r_state.mins == '0) &&
                      (r_state.secs.tens == 4'd0) && (r_state.secs.ones <= 4'd1);
        unique case (i_word.ctl.req_type)
            REQ_TICK: begin
                if (!r_state.finished && !r_state.paused) begin
                    n_state = last_second ? DONE_STATE : dec_time(r_state);
                end
            end
            REQ_PAUSE: begin
                if (!r_state.finished) begin
                    n_state.paused = !r_state.paused;
                end
            end
            REQ_LOAD: begin
                if (i_word.ctl.too_big) begin
                    rejected = 1'b1;
                end else if (i_word.ctl.is_zero) begin
                    n_state = DONE_STATE;
                end else begin
                    n_state.hrs      = i_word.hrs;
                    n_state.mins     = i_word.mins;
                    n_state.secs     = split_bcd({1'b0, i_word.secs});
                    n_state.paused   = 1'b0;
                    n_state.finished = 1'b0;
                end
            end
            REQ_PIXEL: begin
                color = pix_color;
            end
            default: begin
                color = 32'd0;
            end
        endcase
    end

    // Build the result word from the new state
    always_comb begin
        n_out.pixel_color   = color;
        n_out.hours_left    = bcd_to_bin(n_state.hrs);
        n_out.minutes_left  = 6'(bcd_to_bin(n_state.mins));
        n_out.seconds_left  = 6'(bcd_to_bin(n_state.secs));
        n_out.is_paused     = n_state.paused;
        n_out.is_finished   = n_state.finished;
        n_out.load_rejected = rejected;
    end

    // Commit state and hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) r_out_valid <= i_valid;
            if (take)    r_state     <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out <= n_out;
    end

`ifndef ASSERT_OFF
    // A finished timer shows no time left
    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.finished |-> (r_state.hrs == '0 && r_state.mins == '0 &&
                              r_state.secs == '0))
        else $error("finished timer holds time");

    // A finished timer is never paused
    a_done_unpaused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.finished |-> !r_state.paused)
        else $error("finished timer is paused");

    // Time digits stay decimal and below sixty in minutes and seconds
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_state.secs.tens <= 4'd5 && r_state.secs.ones <= 4'd9 &&
                  r_state.mins.tens <= 4'd5 && r_state.mins.ones <= 4'd9 &&
                  r_state.hrs.tens <= 4'd9 && r_state.hrs.ones <= 4'd9))
        else $error("time digit out of range");

    // State moves only when a word is taken
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_state))
        else $error("state changed without a word");
`endif

endmodule

// ===== rtl/countdown_timer_pixel_display.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_pixel_display: countdown timer with pause and pixel face
// Counts a loaded h:m:s time down on second ticks, toggles pause, and
// answers pixel reads of its 29x5 face with the color at that pixel.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  --------  ---------  -----------------------------  ---------------------
//  request   in         i_valid / o_stall              i_in_data  (t_in_word)
//  result    out        o_valid / i_stall              o_out_data (t_out_word)
//  config    in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  One word is accepted each cycle while o_stall is low; its result word
//  passes the five prep stages and the result register to the output.
//  All requests pass through the five-stage load conversion pipeline ahead
//  of the state stage, which keeps them in order.
//  Synchronous reset clears the time and flags and restores default colors.
//  A held result stalls the result register only; requests keep flowing in
//  until all six stages are full.
//
module countdown_timer_pixel_display
    import cdt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_in_word               i_in_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output t_out_word              o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    t_colors    r_colors;
    logic       prep_valid;
    logic       core_ready;
    t_prep_word prep_word;

    assign o_cfg_ready = 1'b1;

    // Write color registers, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colors.background_color <= RST_BACKGROUND;
            r_colors.running_color    <= RST_RUNNING;
            r_colors.end_color        <= RST_END;
            r_colors.dim_color        <= RST_DIM;
            r_colors.colon_color      <= RST_COLON;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BACKGROUND: r_colors.background_color <= i_cfg_data;
                CFG_RUNNING:    r_colors.running_color    <= i_cfg_data;
                CFG_END:        r_colors.end_color        <= i_cfg_data;
                CFG_DIM:        r_colors.dim_color        <= i_cfg_data;
                CFG_COLON:      r_colors.colon_color      <= i_cfg_data;
                default:        r_colors                  <= r_colors;
            endcase
        end
    end

    cdt_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in_data (i_in_data),
        .o_valid   (prep_valid),
        .i_ready   (core_ready),
        .o_word    (prep_word)
    );

    cdt_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (prep_valid),
        .o_ready    (core_ready),
        .i_word     (prep_word),
        .i_colors   (r_colors),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_data (o_out_data)
    );

endmodule

// ===== tb/sv/countdown_face_checker.sv =====
// ----------------------------------------------------------------------------
// countdown_face_checker: predicts and checks every countdown timer result
// Watches the request, result and register channels of the timer. Keeps its
// own copy of the remaining time, the pause and finish flags and the colours,
// works out the result word of each accepted request and compares each
// accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module countdown_face_checker
    import cdt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_stall,
    input  t_in_word               i_req_word,
    input  logic                   i_res_valid,
    input  logic                   i_res_stall,
    input  t_out_word              i_res_word,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    output int                     o_pending,
    output int                     o_mismatches
);

    // Longest load the timer takes: 99:59:59
    localparam int unsigned MAX_LOAD  = 99 * 3600 + 59 * 60 + 59;
    localparam int unsigned FACE_COLS = 29;

    logic [31:0] color_reg [5];
    int unsigned remain_secs;
    logic        paused;
    logic        finished;
    t_out_word   timer_results_q [$];
    t_out_word   want_word;
    t_out_word   got_word;
    int          mismatch_count;

    assign o_mismatches = mismatch_count;

    // Three font rows of a digit, one octal digit per row, msb leftmost
    function automatic logic [8:0] font_rows(input int unsigned d);
        case (d)
            0: return 9'o757;
            1: return 9'o627;
            2: return 9'o623;
            3: return 9'o636;
            4: return 9'o571;
            5: return 9'o326;
            6: return 9'o477;
            7: return 9'o711;
            8: return 9'o777;
            default: return 9'o771;
        endcase
    endfunction

    // Leftmost column of digit slot k: pairs start at 1, 11 and 21
    function automatic int unsigned slot_x(input int unsigned k);
        return 1 + 10 * (k / 2) + 4 * (k % 2);
    endfunction

    function automatic logic [31:0] face_color(input int unsigned x, input int unsigned y);
        int          slot;
        int unsigned hrs;
        int unsigned mins;
        int unsigned secs;
        int unsigned digit;
        int unsigned dx;
        logic [31:0] ink;
        logic [8:0]  rows;
        hrs  = remain_secs / 3600;
        mins = (remain_secs % 3600) / 60;
        secs = remain_secs % 60;
        if (x >= FACE_COLS || y < 1 || y > 3) begin
            return color_reg[CFG_BACKGROUND];
        end
        if ((x == 9 || x == 19) && (y == 1 || y == 3)) begin
            return color_reg[CFG_COLON];
        end
        slot = -1;
        for (int k = 0; k < 6; k++) begin
            if (x >= slot_x(k) && x < slot_x(k) + 3) begin
                slot = k;
            end
        end
        if (slot < 0) begin
            return color_reg[CFG_BACKGROUND];
        end
        ink = (paused || finished) ? color_reg[CFG_END] : color_reg[CFG_RUNNING];
        case (slot)
            0: digit = hrs / 10;
            1: digit = hrs % 10;
            2: digit = mins / 10;
            3: digit = mins % 10;
            4: digit = secs / 10;
            default: digit = secs % 10;
        endcase
        // dim leading zero hours, then leading zero minutes, until run out
        if (slot < 2 && hrs == 0 && !finished) begin
            ink   = color_reg[CFG_DIM];
            digit = 0;
        end else if (slot >= 2 && slot < 4 && hrs == 0 && mins == 0 && !finished) begin
            ink   = color_reg[CFG_DIM];
            digit = 0;
        end
        dx   = x - slot_x(slot);
        rows = font_rows(digit);
        return rows[8 - 3 * (y - 1) - dx] ? ink : color_reg[CFG_BACKGROUND];
    endfunction

    task automatic run_out();
        remain_secs = 0;
        paused      = 1'b0;
        finished    = 1'b1;
    endtask

    // Advance the timer by one request word and build its result word
    task automatic apply_request(input t_in_word w, output t_out_word r);
        r = '0;
        case (w.req_type)
            REQ_TICK: begin
                if (!paused && !finished) begin
                    if (remain_secs <= 1) begin
                        run_out();
                    end else begin
                        remain_secs = remain_secs - 1;
                    end
                end
            end
            REQ_PAUSE: begin
                if (!finished) begin
                    paused = !paused;
                end
            end
            REQ_LOAD: begin
                if (w.load_seconds > MAX_LOAD) begin
                    r.load_rejected = 1'b1;
                end else if (w.load_seconds == 0) begin
                    run_out();
                end else begin
                    remain_secs = w.load_seconds;
                    paused      = 1'b0;
                    finished    = 1'b0;
                end
            end
            default: begin
                r.pixel_color = face_color(w.pixel_x, w.pixel_y);
            end
        endcase
        r.hours_left   = 7'(remain_secs / 3600);
        r.minutes_left = 6'((remain_secs % 3600) / 60);
        r.seconds_left = 6'(remain_secs % 60);
        r.is_paused    = paused;
        r.is_finished  = finished;
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s expected %h got %h", $time, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            color_reg[CFG_BACKGROUND] = 32'h0000_0000;
            color_reg[CFG_RUNNING]    = 32'hFFFF_FFFF;
            color_reg[CFG_END]        = 32'hFFFF_0000;
            color_reg[CFG_DIM]        = 32'hFF40_4040;
            color_reg[CFG_COLON]      = 32'hFF80_8080;
            remain_secs = 0;
            paused      = 1'b0;
            finished    = 1'b0;
            timer_results_q.delete();
            o_pending <= 0;
        end else begin
            // compare each accepted result word with the oldest prediction
            if (i_res_valid && !i_res_stall) begin
                got_word = i_res_word;
                if (timer_results_q.size() == 0) begin
                    $display("%0t: result word %h with no request waiting", $time, got_word);
                    mismatch_count++;
                end else begin
                    want_word = timer_results_q.pop_front();
                    if (got_word.pixel_color !== want_word.pixel_color)
                        report_field("pixel_color", want_word.pixel_color, got_word.pixel_color);
                    if (got_word.hours_left !== want_word.hours_left)
                        report_field("hours_left", want_word.hours_left, got_word.hours_left);
                    if (got_word.minutes_left !== want_word.minutes_left)
                        report_field("minutes_left", want_word.minutes_left,
                                     got_word.minutes_left);
                    if (got_word.seconds_left !== want_word.seconds_left)
                        report_field("seconds_left", want_word.seconds_left,
                                     got_word.seconds_left);
                    if (got_word.is_paused !== want_word.is_paused)
                        report_field("is_paused", want_word.is_paused, got_word.is_paused);
                    if (got_word.is_finished !== want_word.is_finished)
                        report_field("is_finished", want_word.is_finished, got_word.is_finished);
                    if (got_word.load_rejected !== want_word.load_rejected)
                        report_field("load_rejected", want_word.load_rejected,
                                     got_word.load_rejected);
                end
            end
            // track colour writes, drop writes to unused indexes
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= CFG_COLON) begin
                color_reg[i_cfg_index] = i_cfg_data;
            end
            // predict each accepted request word
            if (i_req_valid && !i_req_stall) begin
                apply_request(i_req_word, want_word);
                timer_results_q.push_back(want_word);
            end
            o_pending <= timer_results_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_countdown_timer_pixel_display.sv =====
// ----------------------------------------------------------------------------
// tb_countdown_timer_pixel_display: testbench top for the countdown timer
// Drives directed and random request words and color register writes into
// the timer, stalls the result channel at random, and lets the checker beside
// the block predict and compare every result word before giving the verdict.
// ----------------------------------------------------------------------------
module tb_countdown_timer_pixel_display;
    import cdt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_MAX      = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = CFG_COLON + 1'b1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    t_in_word               i_in_data;
    logic                   o_valid;
    logic                   i_stall;
    t_out_word              o_out_data;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [31:0]            i_cfg_data;

    int pending;
    int mismatches;
    int cycle_count = 0;
    int idle_max = IDLE_MAX;

    countdown_timer_pixel_display u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_data  (i_in_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    countdown_face_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_stall (o_stall),
        .i_req_word  (i_in_data),
        .i_res_valid (o_valid),
        .i_res_stall (i_stall),
        .i_res_word  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_mismatches(mismatches)
    );

    always #5 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_countdown_timer_pixel_display NOT OK");
            $finish;
        end
    end

    // Result side: hold off a random number of cycles before each word
    initial begin
        int hold;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = $urandom_range(0, idle_max);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    function automatic t_in_word request_word(input logic [1:0] kind, input logic [18:0] secs,
                                              input logic [4:0] x, input logic [2:0] y);
        t_in_word w;
        w.req_type     = kind;
        w.load_seconds = secs;
        w.pixel_x      = x;
        w.pixel_y      = y;
        return w;
    endfunction

    // Mostly ticks, short loads and face reads, with boundary and oversize loads
    function automatic t_in_word random_request();
        t_in_word    w;
        int unsigned pick;
        w.load_seconds = 19'($urandom_range(0, 524287));
        w.pixel_x      = 5'($urandom_range(0, 31));
        w.pixel_y      = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            w.req_type = REQ_TICK;
        end else if (pick < 38) begin
            w.req_type = REQ_PAUSE;
        end else if (pick < 56) begin
            w.req_type = REQ_LOAD;
            pick = $urandom_range(0, 19);
            if (pick < 10) begin
                w.load_seconds = 19'($urandom_range(0, 8));
            end else if (pick < 13) begin
                w.load_seconds = 19'($urandom_range(1, 59) * 60 + $urandom_range(0, 4) - 2);
            end else if (pick < 15) begin
                w.load_seconds = 19'($urandom_range(1, 99) * 3600 + $urandom_range(0, 4) - 2);
            end else if (pick < 18) begin
                w.load_seconds = 19'($urandom_range(0, 359999));
            end else begin
                w.load_seconds = 19'($urandom_range(360000, 524287));
            end
        end else begin
            w.req_type = REQ_PIXEL;
            if ($urandom_range(0, 9) != 0) begin
                w.pixel_x = 5'($urandom_range(0, 28));
                w.pixel_y = 3'($urandom_range(0, 4));
            end
        end
        return w;
    endfunction

    // Wait a random gap, present the word, hold it until taken
    task automatic send_request(input t_in_word w);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic random_phase(input int count);
        repeat (count) send_request(random_request());
    endtask

    // Let every predicted word come back, then let the pipeline go quiet
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write all five colors, then junk to the unused indexes
    task automatic write_palette(input logic [31:0] bg, input logic [31:0] fg_run,
                                 input logic [31:0] fg_stop, input logic [31:0] dim,
                                 input logic [31:0] colon);
        write_reg(CFG_BACKGROUND, bg);
        write_reg(CFG_RUNNING, fg_run);
        write_reg(CFG_END, fg_stop);
        write_reg(CFG_DIM, dim);
        write_reg(CFG_COLON, colon);
        for (int k = CFG_SPARE_FIRST; k < 2 ** CFG_INDEX_W; k++) begin
            write_reg(CFG_INDEX_W'(k), $urandom());
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BACKGROUND;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words on the reset colors
        send_request(request_word(REQ_PIXEL, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_PIXEL, 19'd0, 5'd2, 3'd1));
        send_request(request_word(REQ_LOAD, 19'd359999, 5'd0, 3'd0));
        send_request(request_word(REQ_PIXEL, 19'd0, 5'd1, 3'd1));
        send_request(request_word(REQ_PIXEL, 19'd0, 5'd9, 3'd1));
        send_request(request_word(REQ_PIXEL, 19'd0, 5'd31, 3'd7));
        send_request(request_word(REQ_TICK, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_PAUSE, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_TICK, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_PIXEL, 19'd0, 5'd25, 3'd2));
        send_request(request_word(REQ_PAUSE, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_LOAD, 19'd360000, 5'd0, 3'd0));
        send_request(request_word(REQ_LOAD, 19'd524287, 5'd0, 3'd0));
        send_request(request_word(REQ_LOAD, 19'd3600, 5'd0, 3'd0));
        send_request(request_word(REQ_TICK, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_PIXEL, 19'd0, 5'd11, 3'd1));
        send_request(request_word(REQ_PIXEL, 19'd0, 5'd1, 3'd2));
        send_request(request_word(REQ_LOAD, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_PAUSE, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_TICK, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_PIXEL, 19'd0, 5'd5, 3'd2));
        send_request(request_word(REQ_LOAD, 19'd1, 5'd0, 3'd0));
        send_request(request_word(REQ_TICK, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_LOAD, 19'd2, 5'd0, 3'd0));
        send_request(request_word(REQ_TICK, 19'd0, 5'd0, 3'd0));
        send_request(request_word(REQ_PIXEL, 19'd0, 5'd28, 3'd4));
        drain_results();

        // Random words under all-zero, all-one and random colors
        write_palette(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                      32'h0000_0000);
        random_phase(200);
        drain_results();
        write_palette(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF);
        random_phase(200);
        drain_results();
        write_palette($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        idle_max = 0;
        random_phase(150);
        idle_max = IDLE_MAX;
        random_phase(300);
        drain_results();

        if (mismatches == 0) begin
            $display("tb_countdown_timer_pixel_display OK");
        end else begin
            $display("tb_countdown_timer_pixel_display NOT OK");
        end
        $finish;
    end

endmodule
